// ===== rtl/core/bfa_pkg.sv =====
// bfa_pkg: types and codes for the bitmap frame allocator
// used by bitmap_frame_allocator
`timescale 1ns / 1ps
package bfa_pkg;
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE = 2'd1;
  localparam logic [1:0] OP_MFREE = 2'd2;
  localparam logic [1:0] OP_MUSED = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [14:0] frame_index;
    logic [15:0] run_length;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [14:0] frame_found;
    logic [31:0] base_address;
    logic [15:0] frames_used;
    logic [15:0] frames_free;
  } rsp_t;
endpackage

// ===== rtl/core/bitmap_frame_allocator.sv =====
// bitmap_frame_allocator: first-fit frame allocator over a bitmap memory
// depends on bfa_pkg
//
// channel  signals                    handshake
// cfg      cfg_we, cfg_data           written when cfg_we high
// request  start, req                 accepted when start && !busy
// result   done, rsp                  valid for the one cycle done is high
//
// an item walks the bitmap one frame at a time through one read-modify-write
// port: alloc scans from frame 0 via S_SRD/S_SCHK per frame, then marks the
// run via S_MRD/S_MWR per frame; free/region ops take S_MRD/S_MWR per frame,
// region ops then S_FIX, S_MRD, S_MWR to force frame 0 used; S_DONE then
// registers done and rsp. after reset or a cfg write a clearing pass sets
// every word used, one word a cycle, busy meanwhile. results cannot stall.
`timescale 1ns / 1ps
module bitmap_frame_allocator #(
  parameter int NUM_FRAMES = 32768,
  parameter int FRAME_BYTES = 4096,
  parameter int WORD_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [15:0] cfg_data,
  input  logic start,
  input  bfa_pkg::req_t req,
  output logic busy,
  output logic done,
  output bfa_pkg::rsp_t rsp
);
  import bfa_pkg::*;
  localparam int WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam int FW = ($clog2(NUM_FRAMES) + 1 > 16) ? $clog2(NUM_FRAMES) + 1 : 16;
  localparam int SH = $clog2(FRAME_BYTES);

  localparam logic [2:0] S_CLR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SRD = 3'd2;
  localparam logic [2:0] S_SCHK = 3'd3;
  localparam logic [2:0] S_MRD = 3'd4;
  localparam logic [2:0] S_MWR = 3'd5;
  localparam logic [2:0] S_FIX = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic [2:0] state;
  logic [AW-1:0] clr_addr;
  logic [FW-1:0] blocks, used, f, first, run, len, cnt;
  logic [1:0] op, status;
  logic setv, fix0, we;
  logic [AW-1:0] waddr, raddr;
  logic [WORD_BITS-1:0] wdata;
  logic [FW-1:0] cfgv;
  logic [FW:0] sum;
  logic [FW-1:0] f_end;
  logic bitv;

  assign waddr = (state == S_CLR) ? clr_addr : f[BW+AW-1:BW];
  assign raddr = f[BW+AW-1:BW];
  assign bitv = rdata[f[BW-1:0]];

  always_comb begin
    wdata = rdata;
    wdata[f[BW-1:0]] = setv;
    if (state == S_CLR) begin
      wdata = '1;
    end
  end
  assign we = (state == S_CLR) || (state == S_MWR);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    cfgv = FW'(cfg_data);
    if (cfg_data == 16'd0) begin
      cfgv = FW'(1);
    end else if (32'(cfg_data) > NUM_FRAMES) begin
      cfgv = FW'(NUM_FRAMES);
    end
    sum = (FW+1)'(req.frame_index) + (FW+1)'(req.run_length);
  end
  assign f_end = first + len;
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      blocks <= FW'(NUM_FRAMES);
      used <= FW'(NUM_FRAMES);
    end else if (cfg_we) begin
      state <= S_CLR;
      clr_addr <= '0;
      blocks <= cfgv;
      used <= cfgv;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == WORDS - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op <= req.op;
            len <= FW'(req.run_length);
            status <= ST_OK;
            fix0 <= 1'b0;
            setv <= (req.op == OP_ALLOC) || (req.op == OP_MUSED);
            if (req.run_length == 16'd0) begin
              status <= ST_ZERO;
              state <= S_DONE;
            end else if (req.op == OP_ALLOC) begin
              f <= '0;
              run <= '0;
              if (FW'(req.run_length) > blocks - used) begin
                status <= ST_OOM;
                state <= S_DONE;
              end else begin
                state <= S_SRD;
              end
            end else if (sum > (FW+1)'(blocks)) begin
              status <= ST_RANGE;
              state <= S_DONE;
            end else begin
              f <= FW'(req.frame_index);
              first <= FW'(req.frame_index);
              cnt <= '0;
              state <= S_MRD;
            end
          end
        end
        S_SRD: begin
          if (f >= blocks) begin
            status <= ST_OOM;
            state <= S_DONE;
          end else begin
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (bitv) begin
            run <= '0;
            f <= f + 1'b1;
            state <= S_SRD;
          end else begin
            if (run == '0) begin
              first <= f;
            end
            run <= run + 1'b1;
            if (run + 1'b1 == len) begin
              f <= (run == '0) ? f : first;
              if (run == '0) begin
                first <= f;
              end
              cnt <= '0;
              state <= S_MRD;
            end else begin
              f <= f + 1'b1;
              state <= S_SRD;
            end
          end
        end
        S_MRD: state <= S_MWR;
        S_MWR: begin
          if (bitv != setv) begin
            used <= setv ? used + 1'b1 : used - 1'b1;
          end
          if (cnt + 1'b1 == len) begin
            if (fix0) begin
              state <= S_DONE;
            end else if (op == OP_MFREE || op == OP_MUSED) begin
              f <= '0;
              setv <= 1'b1;
              fix0 <= 1'b1;
              cnt <= len - 1'b1;
              state <= S_FIX;
            end else begin
              state <= S_DONE;
            end
          end else begin
            cnt <= cnt + 1'b1;
            f <= f + 1'b1;
            state <= S_MRD;
          end
        end
        S_FIX: state <= S_MRD;
        S_DONE: begin
          done <= 1'b1;
          rsp.status <= status;
          rsp.frame_found <= (op == OP_ALLOC && status == ST_OK) ? first[14:0] : '0;
          rsp.base_address <= (op == OP_ALLOC && status == ST_OK) ?
              32'(64'(first) << SH) : '0;
          rsp.frames_used <= 16'(used);
          rsp.frames_free <= 16'(blocks - used);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_used: assert property (@(posedge clk) disable iff (rst) used <= blocks)
    else $error("used count above block count");
  a_done: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");
  a_acc: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && !cfg_we) |=> busy)
    else $error("item accepted but not busy");
  a_end: assert property (@(posedge clk) disable iff (rst)
      (state == S_MWR && op == OP_ALLOC) |-> f < f_end)
    else $error("alloc mark beyond run");
endmodule
